@@ src/vector_cosine_similarity_2d_assert.svh @@
// Assertion macros, clocked on clk, disabled during rst
`ifndef VECTOR_COSINE_SIMILARITY_2D_ASSERT_SVH
`define VECTOR_COSINE_SIMILARITY_2D_ASSERT_SVH

`define VCS2D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define VCS2D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/vcs2d_pkg.sv @@
`default_nettype none
package vcs2d_pkg;

  localparam int CW  = 16;
  localparam int F   = 14;
  localparam int PW  = 2 * CW;
  localparam int DW  = PW + 1;
  localparam int MW  = 2 * PW;
  localparam int W   = MW + 2 * F + 2;
  localparam int RB  = F + 1;
  localparam int OW  = 16;
  localparam logic [OW-1:0] ONE = OW'(1) << F;

  typedef struct packed {
    logic          valid;
    logic          neg;
    logic          zero;
    logic [W-1:0]  rem;
    logic [W-1:0]  acc;
    logic [W-1:0]  inc;
    logic [RB-1:0] root;
  } cell_t;

endpackage
`default_nettype wire

@@ src/vcs2d_front.sv @@
`default_nettype none
module vcs2d_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        valid,
  input  wire logic signed [vcs2d_pkg::CW-1:0] ax,
  input  wire logic signed [vcs2d_pkg::CW-1:0] ay,
  input  wire logic signed [vcs2d_pkg::CW-1:0] bx,
  input  wire logic signed [vcs2d_pkg::CW-1:0] by,
  output vcs2d_pkg::cell_t                 head
);

  logic                             v1, v2, v3;
  logic signed [vcs2d_pkg::PW-1:0]  pax, pay, pbx, pby, pxx, pyy;
  logic        [vcs2d_pkg::PW-1:0]  sa, sb;
  logic signed [vcs2d_pkg::DW-1:0]  dot;
  logic                             neg, zero;
  logic        [vcs2d_pkg::MW-1:0]  num, den;
  logic signed [vcs2d_pkg::DW-1:0]  dot_abs;
  logic        [vcs2d_pkg::PW-1:0]  mag;

  assign dot_abs = dot[vcs2d_pkg::DW-1] ? -dot : dot;
  assign mag     = dot_abs[vcs2d_pkg::PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (en) begin
      pax <= ax * ax;
      pay <= ay * ay;
      pbx <= bx * bx;
      pby <= by * by;
      pxx <= ax * bx;
      pyy <= ay * by;
      sa  <= $unsigned(pax) + $unsigned(pay);
      sb  <= $unsigned(pbx) + $unsigned(pby);
      dot <= vcs2d_pkg::DW'(pxx) + vcs2d_pkg::DW'(pyy);
      neg  <= dot[vcs2d_pkg::DW-1];
      zero <= (sa == '0) || (sb == '0);
      num  <= vcs2d_pkg::MW'(mag) * vcs2d_pkg::MW'(mag);
      den  <= vcs2d_pkg::MW'(sa) * vcs2d_pkg::MW'(sb);
    end
  end

  always_comb begin
    head.valid = v3;
    head.neg   = neg;
    head.zero  = zero;
    head.rem   = vcs2d_pkg::W'(num) << (2 * vcs2d_pkg::F);
    head.inc   = vcs2d_pkg::W'(den) << (2 * vcs2d_pkg::F);
    head.acc   = '0;
    head.root  = '0;
  end

endmodule
`default_nettype wire

@@ src/vcs2d_cell.sv @@
`default_nettype none
module vcs2d_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire vcs2d_pkg::cell_t d,
  output vcs2d_pkg::cell_t      q
);

  logic [vcs2d_pkg::W-1:0] trial;
  logic                    take;

  assign trial = d.acc + d.inc;
  assign take  = trial <= d.rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
    if (en) begin
      q.neg  <= d.neg;
      q.zero <= d.zero;
      q.rem  <= take ? d.rem - trial : d.rem;
      q.acc  <= (d.acc >> 1) + (take ? d.inc : '0);
      q.inc  <= d.inc >> 2;
      q.root <= {d.root[vcs2d_pkg::RB-2:0], take};
    end
  end

endmodule
`default_nettype wire

@@ src/vector_cosine_similarity_2d.sv @@
// channel | valid      | stall      | payload
// pair    | pair_valid | pair_stall | first_x, first_y, second_x, second_y
// cos     | cos_valid  | cos_stall  | cosine, zero_vector
// One pair per cycle unless the pipe is frozen; 3 multiply/sum stages, one cell per
// root bit (15), and the output register.
// A held result with cos_stall high freezes the whole pipe and raises pair_stall.
// Reset clears the valid bits only.
`default_nettype none
module vector_cosine_similarity_2d (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            pair_valid,
  output logic                                 pair_stall,
  input  wire logic signed [vcs2d_pkg::CW-1:0] first_x,
  input  wire logic signed [vcs2d_pkg::CW-1:0] first_y,
  input  wire logic signed [vcs2d_pkg::CW-1:0] second_x,
  input  wire logic signed [vcs2d_pkg::CW-1:0] second_y,
  output logic                                 cos_valid,
  input  wire logic                            cos_stall,
  output logic signed [vcs2d_pkg::OW-1:0]      cosine,
  output logic                                 zero_vector
);

  logic             en;
  vcs2d_pkg::cell_t chain [0:vcs2d_pkg::RB];
  vcs2d_pkg::cell_t tail;
  logic [vcs2d_pkg::OW-1:0] mag;

  assign en         = !(cos_valid && cos_stall);
  assign pair_stall = !en;

  vcs2d_front u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .valid (pair_valid),
    .ax    (first_x),
    .ay    (first_y),
    .bx    (second_x),
    .by    (second_y),
    .head  (chain[0])
  );

  for (genvar i = 0; i < vcs2d_pkg::RB; i++) begin : g_cell
    vcs2d_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  assign tail = chain[vcs2d_pkg::RB];
  assign mag  = vcs2d_pkg::OW'(tail.root);

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_valid <= 1'b0;
    end else if (en) begin
      cos_valid <= tail.valid;
    end
    if (en) begin
      zero_vector <= tail.zero;
      cosine      <= tail.zero ? vcs2d_pkg::ONE : (tail.neg ? -mag : mag);
    end
  end

`include "vector_cosine_similarity_2d_assert.svh"

  `VCS2D_ASSERT_IMP(a_zero_one, cos_valid && zero_vector, cosine == vcs2d_pkg::ONE, "zero pair not one")
  `VCS2D_ASSERT_IMP(a_range, cos_valid, (cosine <= $signed(vcs2d_pkg::ONE)) && (cosine >= -$signed(vcs2d_pkg::ONE)), "cosine out of range")
  `VCS2D_ASSERT_NXT(a_hold, cos_valid && cos_stall, cos_valid && $stable(cosine) && $stable(zero_vector), "held result changed")

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  typedef struct {
    logic signed [vcs2d_pkg::OW-1:0] cosine;
    logic                            zero_vector;
  } cos_result_t;

  class cosine_scoreboard;
    cos_result_t pending[$];
    int errors = 0;
    int checked = 0;
    int zero_seen = 0;
    int neg_seen = 0;

    function void note_pair(logic signed [vcs2d_pkg::CW-1:0] ax,
                            logic signed [vcs2d_pkg::CW-1:0] ay,
                            logic signed [vcs2d_pkg::CW-1:0] bx,
                            logic signed [vcs2d_pkg::CW-1:0] by);
      longint dot, len_a, len_b, mag;
      logic [127:0] num, den, prod;
      int lo, hi, mid;
      cos_result_t r;
      dot = longint'(ax) * longint'(bx) + longint'(ay) * longint'(by);
      len_a = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay);
      len_b = longint'(bx) * longint'(bx) + longint'(by) * longint'(by);
      if (len_a == 0 || len_b == 0) begin
        r.cosine = vcs2d_pkg::ONE;
        r.zero_vector = 1'b1;
      end else begin
        mag = (dot < 0) ? -dot : dot;
        num = 128'(mag);
        num = (num * num) << (2 * vcs2d_pkg::F);
        den = 128'(len_a) * 128'(len_b);
        lo = 0;
        hi = 1 << vcs2d_pkg::F;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          prod = 128'(longint'(mid) * longint'(mid)) * den;
          if (prod <= num) lo = mid;
          else hi = mid - 1;
        end
        r.cosine = (dot < 0) ? vcs2d_pkg::OW'(-lo) : vcs2d_pkg::OW'(lo);
        r.zero_vector = 1'b0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [vcs2d_pkg::OW-1:0] cosine, logic zero_vector);
      cos_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transfer: cosine=%0d zero_vector=%0b",
               cosine, zero_vector);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.zero_vector) zero_seen++;
      if (e.cosine < 0) neg_seen++;
      if (cosine !== e.cosine) begin
        $error("cosine: expected %0d, actual %0d", e.cosine, cosine);
        errors++;
      end
      if (zero_vector !== e.zero_vector) begin
        $error("zero_vector: expected %0b, actual %0b", e.zero_vector, zero_vector);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pair_valid = 1'b0;
  logic pair_stall;
  logic signed [vcs2d_pkg::CW-1:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
  logic cos_valid;
  logic cos_stall = 1'b0;
  logic signed [vcs2d_pkg::OW-1:0] cosine;
  logic zero_vector;

  cosine_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int pairs_sent = 0;

  always #5 clk = ~clk;

  vector_cosine_similarity_2d dut (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_stall(pair_stall),
    .first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
    .cos_valid(cos_valid), .cos_stall(cos_stall),
    .cosine(cosine), .zero_vector(zero_vector)
  );

  always @(posedge clk) begin
    if (!rst && cos_valid && !cos_stall) sb.check_result(cosine, zero_vector);
    cos_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && ((cos_valid && !cos_stall) || (pair_valid && !pair_stall)))
      quiet_cycles <= 0;
    else if (!rst)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_pair(logic signed [vcs2d_pkg::CW-1:0] ax,
                           logic signed [vcs2d_pkg::CW-1:0] ay,
                           logic signed [vcs2d_pkg::CW-1:0] bx,
                           logic signed [vcs2d_pkg::CW-1:0] by);
    while ($urandom_range(99) < send_idle_pct) begin
      pair_valid <= 1'b0;
      @(posedge clk);
    end
    pair_valid <= 1'b1;
    first_x <= ax;
    first_y <= ay;
    second_x <= bx;
    second_y <= by;
    do @(posedge clk); while (pair_stall);
    sb.note_pair(ax, ay, bx, by);
    pairs_sent++;
  endtask

  task automatic send_ints(int ax, int ay, int bx, int by);
    send_pair(vcs2d_pkg::CW'(ax), vcs2d_pkg::CW'(ay), vcs2d_pkg::CW'(bx), vcs2d_pkg::CW'(by));
  endtask

  task automatic drain_results();
    pair_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [vcs2d_pkg::CW-1:0] pick_coord(int mode);
    case (mode)
      0: return vcs2d_pkg::CW'($urandom);
      1: return vcs2d_pkg::CW'($urandom_range(16) - 8);
      2: begin
        case ($urandom_range(5))
          0: return vcs2d_pkg::CW'(-32768);
          1: return vcs2d_pkg::CW'(32767);
          2: return vcs2d_pkg::CW'(-32767);
          3: return vcs2d_pkg::CW'(0);
          4: return vcs2d_pkg::CW'(1);
          default: return vcs2d_pkg::CW'(-1);
        endcase
      end
      default: return vcs2d_pkg::CW'(int'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  task automatic send_random_pair();
    int mode, k;
    logic signed [vcs2d_pkg::CW-1:0] ax, ay;
    mode = $urandom_range(3);
    ax = pick_coord(mode);
    ay = pick_coord(mode);
    k = $urandom_range(9);
    if (k == 0) begin
      send_pair(ax, ay, ax, ay);
    end else if (k == 1) begin
      send_pair(ax, ay, -ay, ax);
    end else if (k == 2) begin
      send_pair(ax, ay, ax >>> 3, ay >>> 3);
    end else if (k == 3) begin
      send_pair(ax, ay, -ax, -ay);
    end else begin
      mode = $urandom_range(3);
      send_pair(ax, ay, pick_coord(mode), pick_coord(mode));
    end
  endtask

  initial begin
    int pct_send[3];
    int pct_recv[3];
    int waited;
    pct_send = '{23, 55, 0};
    pct_recv = '{55, 23, 0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send_ints(0, 0, 0, 0);
    send_ints(0, 0, 5, -7);
    send_ints(3, 4, 0, 0);
    send_ints(-32768, -32768, -32768, -32768);
    send_ints(-32768, -32768, 32767, 32767);
    send_ints(32767, 32767, 32767, 32767);
    send_ints(-32768, 0, 32767, 0);
    send_ints(-32768, 32767, 32767, -32768);
    send_ints(-32768, 32767, -32768, 32767);
    send_ints(1, 0, 0, 1);
    send_ints(1, 0, -1, 0);
    send_ints(1, 0, 1, 0);
    send_ints(1, 1, 1, 0);
    send_ints(3, 4, 4, 3);
    send_ints(3, 4, -4, -3);
    send_ints(1, 0, 32767, 1);
    send_ints(1, 0, -32768, 1);
    send_ints(-1, -1, 32767, -32768);
    send_ints(32767, 0, 0, -32768);
    send_ints(-5, 12, 12, 5);
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = pct_send[ph];
      recv_stall_pct = pct_recv[ph];
      for (int i = 0; i < 430; i++) send_random_pair();
      drain_results();
    end

    waited = 0;
    while (sb.pending.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    $display("Covered %0d pairs, %0d results checked: %0d zero-vector, %0d negative.",
             pairs_sent, sb.checked, sb.zero_seen, sb.neg_seen);
    $display("Idle mixes: sender/receiver 23/55, 55/23 and none.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
